FILE: hdl/keyword_token_lexer_unit_macros.svh
`ifndef KEYWORD_TOKEN_LEXER_UNIT_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_UNIT_MACROS_SVH
// ---------------------------------------------------------------------------
// Assertion macros for the keyword token lexer
// Same-cycle and next-cycle implication checks, disabled while in reset.
// ---------------------------------------------------------------------------

// consequent must hold in the cycle of the antecedent
`define KLX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("klx same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define KLX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("klx next-cycle check failed");

`endif

FILE: hdl/klx_pkg.sv
// ---------------------------------------------------------------------------
// klx_pkg
// Shared types, constants and the keyword table of the keyword token lexer.
// ---------------------------------------------------------------------------
package klx_pkg;

    localparam int KLX_MAX_TOKEN_LENGTH = 255;
    localparam int KLX_TEXT_BYTES       = 65536;
    localparam int KLX_QUEUE_DEPTH      = 4;
    localparam int KLX_KEYWORDS         = 14;

    typedef enum logic [2:0] {
        SCAN_IDLE    = 3'd0,
        SCAN_IDENT   = 3'd1,
        SCAN_NUMBER  = 3'd2,
        SCAN_NUMWORD = 3'd3,
        SCAN_BANG    = 3'd4,
        SCAN_SLASH   = 3'd5,
        SCAN_COMMENT = 3'd6
    } t_scan_mode;

    typedef enum logic [4:0] {
        KIND_END    = 5'd0,
        KIND_EOL    = 5'd1,
        KIND_PERIOD = 5'd2,
        KIND_GT     = 5'd3,
        KIND_LT     = 5'd4,
        KIND_EQ     = 5'd5,
        KIND_NEQ    = 5'd6,
        KIND_NOT    = 5'd7,
        KIND_NUMBER = 5'd8,
        KIND_IDENT  = 5'd9,
        KIND_PSH    = 5'd10,
        KIND_POP    = 5'd11,
        KIND_JMP    = 5'd12,
        KIND_LOG    = 5'd13,
        KIND_ADD    = 5'd14,
        KIND_SUB    = 5'd15,
        KIND_MUL    = 5'd16,
        KIND_DIV    = 5'd17,
        KIND_AND    = 5'd18,
        KIND_OR     = 5'd19,
        KIND_NOR    = 5'd20,
        KIND_NAND   = 5'd21,
        KIND_XOR    = 5'd22
    } t_token_kind;

    typedef struct packed {
        t_token_kind kind;
        logic [15:0] offset;
        logic [7:0]  length;
        logic [31:0] value;
        logic        last;
    } t_token;

    // up to two tokens handed from the scanner to the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_push;

    typedef struct packed {
        logic not_empty;
        logic room_two;
    } t_queue_status;

    typedef struct packed {
        logic [31:0] chars;
        logic [2:0]  len;
        t_token_kind kind;
    } t_kw_entry;

    // identifier bytes packed with the first byte highest
    localparam t_kw_entry KLX_KW_TABLE [KLX_KEYWORDS] = '{
        '{{8'h00, "psh"}, 3'd3, KIND_PSH},
        '{{8'h00, "pop"}, 3'd3, KIND_POP},
        '{{8'h00, "jmp"}, 3'd3, KIND_JMP},
        '{{8'h00, "log"}, 3'd3, KIND_LOG},
        '{{8'h00, "add"}, 3'd3, KIND_ADD},
        '{{8'h00, "sub"}, 3'd3, KIND_SUB},
        '{{8'h00, "mul"}, 3'd3, KIND_MUL},
        '{{8'h00, "div"}, 3'd3, KIND_DIV},
        '{{8'h00, "and"}, 3'd3, KIND_AND},
        '{{16'h0000, "or"}, 3'd2, KIND_OR},
        '{{8'h00, "nor"}, 3'd3, KIND_NOR},
        '{"nand", 3'd4, KIND_NAND},
        '{{8'h00, "not"}, 3'd3, KIND_NOT},
        '{{8'h00, "xor"}, 3'd3, KIND_XOR}
    };

    // length code 0 means "longer than four", which matches nothing
    function automatic t_token_kind klx_keyword_kind(input logic [31:0] chars,
                                                     input logic [2:0]  len);
        t_token_kind kind;
        kind = KIND_IDENT;
        for (int i = 0; i < KLX_KEYWORDS; i++) begin
            if (KLX_KW_TABLE[i].chars == chars && KLX_KW_TABLE[i].len == len) begin
                kind = KLX_KW_TABLE[i].kind;
            end
        end
        return kind;
    endfunction

endpackage

FILE: hdl/klx_stream_if.sv
// ---------------------------------------------------------------------------
// klx stream interfaces
// Valid/ready channels for source bytes and for tokens.
// ---------------------------------------------------------------------------
interface klx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface klx_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_offset;
    logic [7:0]  token_length;
    logic [31:0] number_value;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_offset,
                    output token_length, output number_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_offset,
                    input token_length, input number_value, input last_of_run,
                    output ready);
endinterface

FILE: hdl/klx_front.sv
// ---------------------------------------------------------------------------
// klx_front
// Byte scanner: classifies each byte, tracks the pending token and hands
// zero, one or two finished tokens to the queue per accepted byte.
// ---------------------------------------------------------------------------
module klx_front #(
    parameter int MAX_TOKEN_LENGTH = klx_pkg::KLX_MAX_TOKEN_LENGTH,
    parameter int TEXT_BYTES       = klx_pkg::KLX_TEXT_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    klx_byte_if.sink               i_byte,
    input  klx_pkg::t_queue_status i_qstat,
    output klx_pkg::t_push         o_push
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int POS_W = $clog2(TEXT_BYTES);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    klx_pkg::t_scan_mode r_mode, n_mode;
    logic [31:0]         r_kw, n_kw;
    logic [POS_W-1:0]    r_start, n_start;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [31:0]         r_acc, n_acc;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_star, n_star;

    logic [7:0]  w_c;
    logic        w_accept;
    logic        w_letter, w_digit, w_word_ch;
    logic [3:0]  w_digit_val;
    logic [35:0] w_acc_wide;
    logic [31:0] w_acc_sat;
    logic [LEN_W-1:0] w_len_grow;
    logic [15:0] w_len_wide;
    logic [7:0]  w_len_sat;
    logic [2:0]  w_len_code;
    klx_pkg::t_token_kind w_kw_kind;

    logic                 w_fresh;
    logic                 w_close_vld;
    klx_pkg::t_token_kind w_close_kind;
    logic [7:0]           w_close_len;
    logic [31:0]          w_close_val;
    logic                 w_new_vld;
    klx_pkg::t_token_kind w_new_kind;
    logic [7:0]           w_new_len;
    klx_pkg::t_token      w_close_tok, w_new_tok;

    assign w_c      = i_byte.text_byte;
    assign w_accept = i_byte.valid && i_byte.ready;
    assign i_byte.ready = i_qstat.room_two;

    assign w_letter  = (w_c >= "a" && w_c <= "z") || (w_c >= "A" && w_c <= "Z");
    assign w_digit   = (w_c >= "0" && w_c <= "9");
    assign w_word_ch = w_letter || w_digit || (w_c == CH_UNDER);

    // decimal accumulate as acc*8 + acc*2 + digit, saturating at 32 bits
    assign w_digit_val = 4'(w_c - CH_ZERO);
    assign w_acc_wide  = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1) + 36'(w_digit_val);
    assign w_acc_sat   = (|w_acc_wide[35:32]) ? 32'hFFFF_FFFF : w_acc_wide[31:0];

    assign w_len_grow = (r_len < LEN_W'(MAX_TOKEN_LENGTH)) ? r_len + LEN_W'(1) : r_len;
    assign w_len_wide = 16'(r_len);
    assign w_len_sat  = (w_len_wide > 16'd255) ? 8'hFF : w_len_wide[7:0];
    assign w_len_code = (r_len <= LEN_W'(4)) ? 3'(r_len) : 3'd0;
    assign w_kw_kind  = klx_pkg::klx_keyword_kind(r_kw, w_len_code);

    // token outputs of the scanner
    always_comb begin
        w_fresh      = 1'b1;
        w_close_vld  = 1'b0;
        w_close_kind = klx_pkg::KIND_END;
        w_close_len  = 8'd0;
        w_close_val  = 32'd0;
        unique case (r_mode)
            klx_pkg::SCAN_IDENT: begin
                if (w_word_ch) begin
                    w_fresh = 1'b0;
                end else begin
                    w_close_vld  = 1'b1;
                    w_close_kind = w_kw_kind;
                    w_close_len  = w_len_sat;
                end
            end
            klx_pkg::SCAN_NUMBER: begin
                if (w_digit || w_letter) begin
                    w_fresh = 1'b0;
                end else begin
                    w_close_vld  = 1'b1;
                    w_close_kind = klx_pkg::KIND_NUMBER;
                    w_close_len  = w_len_sat;
                    w_close_val  = r_acc;
                end
            end
            klx_pkg::SCAN_NUMWORD: begin
                if (w_digit || w_letter) begin
                    w_fresh = 1'b0;
                end else begin
                    w_close_vld  = 1'b1;
                    w_close_kind = klx_pkg::KIND_IDENT;
                    w_close_len  = w_len_sat;
                end
            end
            klx_pkg::SCAN_BANG: begin
                w_close_vld = 1'b1;
                if (w_c == CH_EQ) begin
                    w_fresh      = 1'b0;
                    w_close_kind = klx_pkg::KIND_NEQ;
                    w_close_len  = 8'd2;
                end else begin
                    w_close_kind = klx_pkg::KIND_NOT;
                    w_close_len  = 8'd1;
                end
            end
            klx_pkg::SCAN_SLASH: begin
                if (w_c == CH_STAR) begin
                    w_fresh = 1'b0;
                end else begin
                    w_close_vld  = 1'b1;
                    w_close_kind = klx_pkg::KIND_END;
                    w_close_len  = 8'd1;
                end
            end
            klx_pkg::SCAN_COMMENT: begin
                if (w_c != CH_NUL) begin
                    w_fresh = 1'b0;
                end
            end
            klx_pkg::SCAN_IDLE: begin
            end
            default: begin
            end
        endcase

        w_new_vld  = 1'b0;
        w_new_kind = klx_pkg::KIND_END;
        w_new_len  = 8'd1;
        if (w_fresh) begin
            if (w_c == CH_NUL) begin
                w_new_vld = 1'b1;
                w_new_len = 8'd0;
            end else if (!(w_word_ch || w_c == CH_AT)) begin
                case (w_c) inside
                    CH_SPACE, CH_TAB, CH_CR, CH_SLASH, CH_BANG: begin
                        // skipped or held pending
                    end
                    CH_LF, CH_SEMI: begin
                        w_new_vld  = 1'b1;
                        w_new_kind = klx_pkg::KIND_EOL;
                    end
                    CH_PERIOD: begin
                        w_new_vld  = 1'b1;
                        w_new_kind = klx_pkg::KIND_PERIOD;
                    end
                    CH_GT: begin
                        w_new_vld  = 1'b1;
                        w_new_kind = klx_pkg::KIND_GT;
                    end
                    CH_LT: begin
                        w_new_vld  = 1'b1;
                        w_new_kind = klx_pkg::KIND_LT;
                    end
                    CH_EQ: begin
                        w_new_vld  = 1'b1;
                        w_new_kind = klx_pkg::KIND_EQ;
                    end
                    default: begin
                        w_new_vld = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        w_close_tok.kind   = w_close_kind;
        w_close_tok.offset = 16'(r_start);
        w_close_tok.length = w_close_len;
        w_close_tok.value  = w_close_val;
        w_close_tok.last   = !w_new_vld;
        w_new_tok.kind     = w_new_kind;
        w_new_tok.offset   = 16'(r_pos);
        w_new_tok.length   = w_new_len;
        w_new_tok.value    = 32'd0;
        w_new_tok.last     = 1'b1;

        o_push.first  = w_close_vld ? w_close_tok : w_new_tok;
        o_push.second = w_new_tok;
        o_push.count  = w_accept ? (2'(w_close_vld) + 2'(w_new_vld)) : 2'd0;
    end

    // next scanner state
    always_comb begin
        n_mode  = r_mode;
        n_kw    = r_kw;
        n_start = r_start;
        n_len   = r_len;
        n_acc   = r_acc;
        n_star  = r_star;
        unique case (r_mode)
            klx_pkg::SCAN_IDENT: begin
                if (w_word_ch) begin
                    if (r_len < LEN_W'(4)) begin
                        n_kw = {r_kw[23:0], w_c};
                    end
                    n_len = w_len_grow;
                end
            end
            klx_pkg::SCAN_NUMBER: begin
                if (w_digit) begin
                    n_acc = w_acc_sat;
                    n_len = w_len_grow;
                end else if (w_letter) begin
                    n_mode = klx_pkg::SCAN_NUMWORD;
                    n_len  = w_len_grow;
                end
            end
            klx_pkg::SCAN_NUMWORD: begin
                if (w_digit || w_letter) begin
                    n_len = w_len_grow;
                end
            end
            klx_pkg::SCAN_BANG: begin
                if (w_c == CH_EQ) begin
                    n_mode = klx_pkg::SCAN_IDLE;
                end
            end
            klx_pkg::SCAN_SLASH: begin
                if (w_c == CH_STAR) begin
                    n_mode = klx_pkg::SCAN_COMMENT;
                    n_star = 1'b0;
                end
            end
            klx_pkg::SCAN_COMMENT: begin
                if (w_c != CH_NUL) begin
                    if (r_star && w_c == CH_SLASH) begin
                        n_mode = klx_pkg::SCAN_IDLE;
                    end
                    n_star = (w_c == CH_STAR);
                end
            end
            klx_pkg::SCAN_IDLE: begin
            end
            default: begin
                n_mode = klx_pkg::SCAN_IDLE;
            end
        endcase

        if (w_fresh) begin
            n_mode = klx_pkg::SCAN_IDLE;
            n_star = 1'b0;
            if (w_c == CH_SLASH) begin
                n_mode  = klx_pkg::SCAN_SLASH;
                n_start = r_pos;
            end else if (w_letter || w_c == CH_UNDER || w_c == CH_AT) begin
                n_mode  = klx_pkg::SCAN_IDENT;
                n_start = r_pos;
                n_len   = LEN_W'(1);
                n_kw    = {24'd0, w_c};
            end else if (w_digit) begin
                n_mode  = klx_pkg::SCAN_NUMBER;
                n_start = r_pos;
                n_len   = LEN_W'(1);
                n_acc   = {28'd0, w_digit_val};
            end else if (w_c == CH_BANG) begin
                n_mode  = klx_pkg::SCAN_BANG;
                n_start = r_pos;
            end
        end

        // end of text, or the last position of the text space, restarts the position count
        if (w_c == CH_NUL) begin
            n_pos = '0;
        end else if (r_pos == POS_W'(TEXT_BYTES - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= klx_pkg::SCAN_IDLE;
            r_kw    <= 32'd0;
            r_start <= '0;
            r_len   <= '0;
            r_acc   <= 32'd0;
            r_pos   <= '0;
            r_star  <= 1'b0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_kw    <= n_kw;
            r_start <= n_start;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_star  <= n_star;
        end
    end

endmodule

FILE: hdl/klx_queue.sv
// ---------------------------------------------------------------------------
// klx_queue
// Short token queue: takes up to two tokens per cycle, gives one per cycle on each pop.
// ---------------------------------------------------------------------------
module klx_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  klx_pkg::t_push         i_push,
    input  logic                   i_pop,
    output klx_pkg::t_token        o_head,
    output klx_pkg::t_queue_status o_qstat
);

    localparam int DEPTH = klx_pkg::KLX_QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    klx_pkg::t_token  r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] w_wr_next;

    assign w_wr_next = r_wr + PTR_W'(1);
    assign o_head    = r_slot[r_rd];

    assign o_qstat.not_empty = (r_count != '0);
    assign o_qstat.room_two  = (r_count <= CNT_W'(DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.count);
        n_rd    = i_pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_slot[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_slot[w_wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/klx_back.sv
// ---------------------------------------------------------------------------
// klx_back
// Output stage: moves the queue head into the token register and holds it
// until the receiver takes the word.
// ---------------------------------------------------------------------------
module klx_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  klx_pkg::t_token        i_head,
    input  klx_pkg::t_queue_status i_qstat,
    output logic                   o_pop,
    klx_token_if.source            o_token
);

    logic            r_vld;
    klx_pkg::t_token r_tok;

    // refill whenever the register is empty or its word leaves this cycle
    assign o_pop = i_qstat.not_empty && (!r_vld || o_token.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (o_token.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tok <= i_head;
        end
    end

    assign o_token.valid        = r_vld;
    assign o_token.token_kind   = r_tok.kind;
    assign o_token.token_offset = r_tok.offset;
    assign o_token.token_length = r_tok.length;
    assign o_token.number_value = r_tok.value;
    assign o_token.last_of_run  = r_tok.last;

endmodule

FILE: hdl/keyword_token_lexer_unit.sv
// Keyword token lexer.
// i_byte carries source text one byte per word; a zero byte ends the text,
// closes any pending token, emits an end token and restarts the offset at 0.
// o_token carries one token per word: kind, byte offset, length, decimal value
// for numbers and a flag on the last token caused by a byte.
// A byte is taken whenever the token queue has room for two entries, so the
// block takes one byte per cycle while the receiver takes a token every cycle
// and no two two-token bytes come without a zero-token byte between them.
// A byte yields zero, one or two tokens; its first token is written to the queue,
// then moves to the output register on o_token; tokens leave one per cycle when taken.
// The four-entry queue between the scanner and the output register absorbs
// the two-token bytes; the scanner state registers feed back through the next-state logic.
// When the receiver stalls, the output register holds its word, the queue
// fills, and i_byte.ready drops once fewer than two entries are free.
// Reset clears the scanner to idle at offset 0 and empties queue and output.
// ---------------------------------------------------------------------------
// keyword_token_lexer_unit
// Top level: byte scanner, token queue and output register.
// ---------------------------------------------------------------------------
`include "keyword_token_lexer_unit_macros.svh"

module keyword_token_lexer_unit #(
    parameter int MAX_TOKEN_LENGTH = klx_pkg::KLX_MAX_TOKEN_LENGTH,
    parameter int TEXT_BYTES       = klx_pkg::KLX_TEXT_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    klx_byte_if.sink     i_byte,
    klx_token_if.source  o_token
);

    klx_pkg::t_push         w_push;
    klx_pkg::t_queue_status w_qstat;
    klx_pkg::t_token        w_head;
    logic                   w_pop;

    klx_front #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .TEXT_BYTES       (TEXT_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_qstat (w_qstat),
        .o_push  (w_push)
    );

    klx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    klx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_token (o_token)
    );

    `KLX_ASSERT_SAME(a_accept_has_room, i_clk, i_rst_n, i_byte.valid && i_byte.ready, w_qstat.room_two)
    `KLX_ASSERT_NEXT(a_refill_output, i_clk, i_rst_n, w_qstat.not_empty && !o_token.valid, o_token.valid)
    `KLX_ASSERT_SAME(a_end_token_last, i_clk, i_rst_n, o_token.valid && o_token.token_kind == klx_pkg::KIND_END && o_token.token_length == 8'd0, o_token.last_of_run)
    `KLX_ASSERT_SAME(a_value_only_number, i_clk, i_rst_n, o_token.valid && o_token.number_value != 32'd0, o_token.token_kind == klx_pkg::KIND_NUMBER)

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for keyword_token_lexer_unit: streams source text into
// the byte channel, mirrors the scanner in a behavioral lexer and checks every
// token word in order. A short directed text comes first. Random text follows,
// mostly well-formed tokens with noise mixed in. A long word and a long number
// at the end saturate token length and number value.
// ---------------------------------------------------------------------------
module tb;
    import klx_pkg::*;

    localparam int RUN_LIMIT      = 1_000_000;
    localparam int RANDOM_BYTES   = 340;
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 80;
    localparam int RX_QUIET_FROM  = 600;
    localparam int RX_QUIET_TO    = 900;
    localparam int TX_QUIET_FROM  = 200;
    localparam int TX_QUIET_TO    = 400;
    localparam int TAIL_CYCLES    = 16;
    localparam int LONG_WORD      = 265;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef struct {
        logic [7:0] text;
        bit         typed;
        t_token     want;
    } t_text_row;

    logic i_clk;
    logic i_rst_n;

    klx_byte_if  byte_bus ();
    klx_token_if token_bus ();

    keyword_token_lexer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_token (token_bus)
    );

    t_text_row text_rows[$];
    t_token    awaited_tokens[$];
    t_token    step_tokens[$];
    int        mismatch_count = 0;
    int        run_cycles = 0;
    bit        src_steady = 1'b0;

    // behavioral copy of the scanner state
    t_scan_mode  lex_mode;
    logic [31:0] lex_chars;
    logic [15:0] lex_start;
    logic [7:0]  lex_len;
    logic [31:0] lex_value;
    logic [15:0] lex_pos;
    logic        lex_star;

    string keyword_words [14] = '{"psh", "pop", "jmp", "log", "add", "sub", "mul",
                                  "div", "and", "or", "nor", "nand", "not", "xor"};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic t_token_kind word_kind(logic [31:0] chars, logic [7:0] len);
        t_token_kind k;
        k = KIND_IDENT;
        if (len == 8'd2 && chars == {16'h0000, "or"}) begin
            k = KIND_OR;
        end else if (len == 8'd4 && chars == "nand") begin
            k = KIND_NAND;
        end else if (len == 8'd3) begin
            case (chars)
                {8'h00, "psh"}: k = KIND_PSH;
                {8'h00, "pop"}: k = KIND_POP;
                {8'h00, "jmp"}: k = KIND_JMP;
                {8'h00, "log"}: k = KIND_LOG;
                {8'h00, "add"}: k = KIND_ADD;
                {8'h00, "sub"}: k = KIND_SUB;
                {8'h00, "mul"}: k = KIND_MUL;
                {8'h00, "div"}: k = KIND_DIV;
                {8'h00, "and"}: k = KIND_AND;
                {8'h00, "nor"}: k = KIND_NOR;
                {8'h00, "not"}: k = KIND_NOT;
                {8'h00, "xor"}: k = KIND_XOR;
                default:        k = KIND_IDENT;
            endcase
        end
        return k;
    endfunction

    function void queue_token(t_token_kind k, logic [15:0] off, logic [7:0] len,
                              logic [31:0] val);
        step_tokens.push_back('{kind: k, offset: off, length: len, value: val, last: 1'b0});
    endfunction

    function void stretch_token();
        if (lex_len != 8'd255) lex_len = lex_len + 8'd1;
    endfunction

    // advance the lexer by one byte and leave its tokens in step_tokens
    function void lex_byte(logic [7:0] c);
        bit          fresh;
        logic [15:0] here;
        logic [63:0] grown;
        t_token_kind k;
        t_token      tail;
        fresh = 1'b1;
        here  = lex_pos;
        k     = KIND_END;
        step_tokens.delete();
        case (lex_mode)
            SCAN_IDENT: begin
                if (is_alpha(c) || is_num(c) || c == "_") begin
                    if (lex_len < 8'd4) lex_chars = {lex_chars[23:0], c};
                    stretch_token();
                    fresh = 1'b0;
                end else begin
                    queue_token(word_kind(lex_chars, lex_len), lex_start, lex_len, 32'd0);
                end
            end
            SCAN_NUMBER: begin
                if (is_num(c)) begin
                    grown = {32'd0, lex_value} * 64'd10 + {56'd0, c - CH_ZERO};
                    lex_value = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
                    stretch_token();
                    fresh = 1'b0;
                end else if (is_alpha(c)) begin
                    lex_mode = SCAN_NUMWORD;
                    stretch_token();
                    fresh = 1'b0;
                end else begin
                    queue_token(KIND_NUMBER, lex_start, lex_len, lex_value);
                end
            end
            SCAN_NUMWORD: begin
                if (is_alpha(c) || is_num(c)) begin
                    stretch_token();
                    fresh = 1'b0;
                end else begin
                    queue_token(KIND_IDENT, lex_start, lex_len, 32'd0);
                end
            end
            SCAN_BANG: begin
                if (c == "=") begin
                    queue_token(KIND_NEQ, lex_start, 8'd2, 32'd0);
                    lex_mode = SCAN_IDLE;
                    fresh = 1'b0;
                end else begin
                    queue_token(KIND_NOT, lex_start, 8'd1, 32'd0);
                end
            end
            SCAN_SLASH: begin
                if (c == "*") begin
                    lex_mode = SCAN_COMMENT;
                    lex_star = 1'b0;
                    fresh = 1'b0;
                end else begin
                    queue_token(KIND_END, lex_start, 8'd1, 32'd0);
                end
            end
            SCAN_COMMENT: begin
                // a zero byte inside a comment falls through to the end token
                if (c != CH_NUL) begin
                    if (lex_star && c == "/") lex_mode = SCAN_IDLE;
                    lex_star = (c == "*");
                    fresh = 1'b0;
                end
            end
            default: ;
        endcase

        if (fresh) begin
            lex_mode = SCAN_IDLE;
            lex_star = 1'b0;
            if (c == CH_NUL) begin
                queue_token(KIND_END, here, 8'd0, 32'd0);
            end else if (c == " " || c == CH_TAB || c == CH_CR) begin
                // skip whitespace
            end else if (c == "/") begin
                lex_mode  = SCAN_SLASH;
                lex_start = here;
            end else if (is_alpha(c) || c == "_" || c == "@") begin
                lex_mode  = SCAN_IDENT;
                lex_start = here;
                lex_len   = 8'd1;
                lex_chars = {24'd0, c};
            end else if (is_num(c)) begin
                lex_mode  = SCAN_NUMBER;
                lex_start = here;
                lex_len   = 8'd1;
                lex_value = {24'd0, c - CH_ZERO};
            end else if (c == "!") begin
                lex_mode  = SCAN_BANG;
                lex_start = here;
            end else begin
                case (c)
                    CH_LF, ";": k = KIND_EOL;
                    ".":        k = KIND_PERIOD;
                    ">":        k = KIND_GT;
                    "<":        k = KIND_LT;
                    "=":        k = KIND_EQ;
                    default:    k = KIND_END;
                endcase
                queue_token(k, here, 8'd1, 32'd0);
            end
        end

        if (c == CH_NUL) begin
            lex_mode = SCAN_IDLE;
            lex_star = 1'b0;
            lex_pos  = 16'd0;
        end else begin
            lex_pos = here + 16'd1;
        end

        if (step_tokens.size() != 0) begin
            tail = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.push_back(tail);
        end
    endfunction

    function void put_byte(logic [7:0] b);
        t_text_row row;
        row.text  = b;
        row.typed = 1'b0;
        row.want  = '0;
        text_rows.push_back(row);
    endfunction

    function void put_typed(logic [7:0] b, t_token_kind k, logic [15:0] off, logic [7:0] len);
        t_text_row row;
        row.text  = b;
        row.typed = 1'b1;
        row.want  = '{kind: k, offset: off, length: len, value: 32'd0, last: 1'b1};
        text_rows.push_back(row);
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] c;
        c = "a" + 8'($urandom_range(25));
        if ($urandom_range(3) == 0) c = c - 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] word_tail_char();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = any_digit();
            1:       c = "_";
            default: c = any_letter();
        endcase
        return c;
    endfunction

    function void put_blank();
        case ($urandom_range(3))
            0:       put_byte(CH_TAB);
            1:       put_byte(CH_CR);
            2:       put_byte(CH_LF);
            default: put_byte(" ");
        endcase
    endfunction

    // one random lexeme, usually followed by a separator
    function void put_fragment();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 20) begin
            put_text(keyword_words[$urandom_range(13)]);
            // near miss: keyword with one more character
            if ($urandom_range(7) == 0) put_byte(word_tail_char());
        end else if (pick < 33) begin
            case ($urandom_range(3))
                0:       put_byte("_");
                1:       put_byte("@");
                default: put_byte(any_letter());
            endcase
            n = $urandom_range(6);
            repeat (n) put_byte(word_tail_char());
        end else if (pick < 46) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
            repeat (n) put_byte(any_digit());
        end else if (pick < 49) begin
            put_text($urandom_range(1) ? "4294967295" : "4294967296");
        end else if (pick < 54) begin
            n = $urandom_range(1, 3);
            repeat (n) put_byte(any_digit());
            put_byte(any_letter());
            n = $urandom_range(2);
            repeat (n) put_byte($urandom_range(1) ? any_letter() : any_digit());
        end else if (pick < 68) begin
            case ($urandom_range(8))
                0:       put_text("\n");
                1:       put_text(";");
                2:       put_text(".");
                3:       put_text(">");
                4:       put_text("<");
                5:       put_text("=");
                6:       put_text("!");
                7:       put_text("!!");
                default: put_text("!=");
            endcase
        end else if (pick < 73) begin
            put_text("/*");
            n = $urandom_range(8);
            repeat (n) begin
                case ($urandom_range(3))
                    0:       put_byte("*");
                    1:       put_byte("/");
                    default: put_byte(8'($urandom_range(1, 255)));
                endcase
            end
            if ($urandom_range(9) == 0) put_byte(CH_NUL);
            else put_text("*/");
        end else if (pick < 77) begin
            put_byte("/");
            put_byte($urandom_range(1) ? any_letter() : "=");
        end else if (pick < 87) begin
            put_byte(8'($urandom_range(1, 255)));
        end else if (pick < 91) begin
            put_byte(CH_NUL);
        end else begin
            put_blank();
        end
        if ($urandom_range(9) < 7) put_blank();
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_row(input t_text_row row);
        while (!src_steady && $urandom_range(99) < 24) begin
            byte_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.text_byte <= row.text;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        lex_byte(row.text);
        if (row.typed) begin
            awaited_tokens.push_back(row.want);
        end else begin
            foreach (step_tokens[i]) awaited_tokens.push_back(step_tokens[i]);
        end
    endtask

    initial begin : stimulus
        int random_end;
        lex_mode  = SCAN_IDLE;
        lex_chars = '0;
        lex_start = '0;
        lex_len   = '0;
        lex_value = '0;
        lex_pos   = '0;
        lex_star  = 1'b0;

        // directed text: end of text, unknown byte, then each token shape
        put_typed(CH_NUL, KIND_END, 16'd0, 8'd0);
        put_typed(8'hFF, KIND_END, 16'd0, 8'd1);
        put_typed("=", KIND_EQ, 16'd1, 8'd1);
        put_text("nand!=!;");
        put_text("/*/*/");
        put_text("/7q.>@/*");
        put_byte(CH_NUL);

        random_end = text_rows.size() + RANDOM_BYTES;
        while (text_rows.size() < random_end) put_fragment();

        // saturate token length and number value from a clean start
        put_byte(CH_NUL);
        put_byte(any_letter());
        repeat (LONG_WORD) put_byte(word_tail_char());
        put_text(" 99999999999999 ");
        put_byte(CH_NUL);

        i_rst_n            <= 1'b0;
        byte_bus.valid     <= 1'b0;
        byte_bus.text_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (text_rows[i]) begin
            src_steady = (i >= TX_QUIET_FROM && i < TX_QUIET_TO);
            send_row(text_rows[i]);
        end
        byte_bus.valid <= 1'b0;

        while (awaited_tokens.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** keyword_token_lexer_unit: PASSED **");
        end else begin
            $display("** keyword_token_lexer_unit: FAILED **");
        end
        $finish;
    end

    initial begin : token_sink
        int rx_cycle;
        rx_cycle = 0;
        token_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_cycle == HOLD_AT) begin
                // hold off long enough for the queue to back up into the byte side
                token_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_cycle += HOLD_CYCLES;
            end else begin
                token_bus.ready <= (rx_cycle >= RX_QUIET_FROM && rx_cycle < RX_QUIET_TO) ||
                                   ($urandom_range(99) >= 24);
                @(posedge i_clk);
                rx_cycle++;
            end
        end
    end

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && token_bus.valid && token_bus.ready) begin
            got = '{kind:   t_token_kind'(token_bus.token_kind),
                    offset: token_bus.token_offset,
                    length: token_bus.token_length,
                    value:  token_bus.number_value,
                    last:   token_bus.last_of_run};
            if (awaited_tokens.size() == 0) begin
                $error("unexpected token word: kind %0d offset %0d", got.kind, got.offset);
                mismatch_count++;
            end else begin
                want = awaited_tokens.pop_front();
                check_field("token_kind", 32'(want.kind), 32'(got.kind));
                check_field("token_offset", 32'(want.offset), 32'(got.offset));
                check_field("token_length", 32'(want.length), 32'(got.length));
                check_field("number_value", want.value, got.value);
                check_field("last_of_run", 32'(want.last), 32'(got.last));
            end
        end
    end

    always @(posedge i_clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles == RUN_LIMIT) begin
            $display("** keyword_token_lexer_unit: FAILED **");
            $finish;
        end
    end

endmodule
